// ===== hdl/bmp565_pkg.sv =====
// Shared constants and types for the BMP 24-bit to RGB565 stream decoder.
package bmp565_pkg;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_PIXELS = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [2:0] KIND_PIXEL     = 3'd0;
    localparam logic [2:0] KIND_BAD_SIG   = 3'd1;
    localparam logic [2:0] KIND_BAD_FMT   = 3'd2;
    localparam logic [2:0] KIND_BAD_OFS   = 3'd3;
    localparam logic [2:0] KIND_OFFSCREEN = 3'd4;

    localparam logic [1:0] CFG_ORIGIN_X      = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y      = 2'd1;
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd3;

    localparam logic [11:0] SCREEN_WIDTH_RESET  = 12'd536;
    localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd240;

    localparam logic [5:0] HDR_SIGNATURE = 6'd1;
    localparam logic [5:0] HDR_OFFSET    = 6'd13;
    localparam logic [5:0] HDR_WIDTH     = 6'd21;
    localparam logic [5:0] HDR_HEIGHT    = 6'd25;
    localparam logic [5:0] HDR_PLANES    = 6'd27;
    localparam logic [5:0] HDR_BPP       = 6'd29;
    localparam logic [5:0] HDR_LAST      = 6'd33;

    localparam logic [31:0] HEADER_LEN    = 32'd34;
    localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
    localparam logic [15:0] BMP_PLANES    = 16'd1;
    localparam logic [15:0] BMP_BPP       = 16'd24;
    localparam logic [7:0]  RED_MASK      = 8'hF8;
    localparam logic [7:0]  GREEN_MASK    = 8'hFC;

    typedef struct packed {
        logic [2:0]  kind;
        logic [17:0] pixel_x;
        logic [17:0] pixel_y;
        logic [15:0] color;
        logic        in_view;
        logic        last;
    } res_t;

endpackage

// ===== hdl/bmp24_stream_to_rgb565_unit.sv =====
// Top level of the BMP 24-bit to RGB565 stream decoder.
//
// Usage:
//   s_* carries one byte of a BMP file per item in tdata; tuser marks the first
//   byte of a new file and restarts parsing. m_* carries one result per item:
//   tuser holds the kind (pixel or error code), tdata the pixel coordinate,
//   color and in-view flag, tlast the final pixel of an image or any error.
//   cfg_* writes origin_x, origin_y, screen_width and screen_height by index;
//   it is always ready; write it only while the block is idle, as the block does not enforce this.
//   Throughput is one byte per cycle while s_tready is high: each byte updates
//   counters and holding registers in the cycle it is accepted. A result is
//   registered onto m_* from the byte that causes it.
//   When the receiver stalls, one further result is held in a skid register;
//   s_tready drops only while that register is full, so bytes that make no
//   result and a single result keep flowing during a stall.
//   Reset (rst_n low) empties both result registers, returns the parser to
//   idle, and loads the register defaults: origin 0,0 and screen 536 by 240.
//   Bytes before the first file start are dropped.
module bmp24_stream_to_rgb565_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] file_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [17:0] pixel_x, [35:18] pixel_y, [51:36] color,
                                   // [52] in_view, [55:53] zero
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] origin_x_reg;
    logic [15:0] origin_y_reg;
    logic [11:0] screen_width_reg;
    logic [11:0] screen_height_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [5:0]  header_count_reg, header_count_next;
    logic [31:0] stream_pos_reg, stream_pos_next;
    logic [31:0] data_offset_reg, data_offset_next;
    logic [15:0] image_width_reg, image_width_next;
    logic [15:0] image_height_reg, image_height_next;
    logic [31:0] header_word_reg, header_word_next;
    logic        format_ok_reg, format_ok_next;
    logic [15:0] row_index_reg, row_index_next;
    logic [15:0] col_index_reg, col_index_next;
    logic [1:0]  byte_in_pixel_reg, byte_in_pixel_next;
    logic [1:0]  pad_left_reg, pad_left_next;
    logic [7:0]  blue_hold_reg, blue_hold_next;
    logic [7:0]  green_hold_reg, green_hold_next;

    logic        out_valid_reg, skid_valid_reg;
    bmp565_pkg::res_t out_reg, skid_reg;

    logic        in_acc;
    logic        take;
    logic        origin_bad;
    logic        fs;
    logic [2:0]  cur_phase;
    logic [5:0]  cur_hc;
    logic [31:0] cur_hw;
    logic        cur_fmt;
    logic [31:0] cur_pos;
    logic [15:0] cur_row;
    logic [15:0] cur_col;
    logic [1:0]  cur_bip;
    logic [1:0]  cur_pad;
    logic        do_pixel;
    logic [17:0] px;
    logic [17:0] py;
    logic        end_row;
    logic        fin;
    logic        fmt_final;
    logic        res_valid;
    bmp565_pkg::res_t res;
    bmp565_pkg::res_t pix_res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_acc    = s_tvalid && s_tready;
    assign take      = out_valid_reg && m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {3'b000, out_reg.in_view, out_reg.color, out_reg.pixel_y, out_reg.pixel_x};

    assign origin_bad = (!origin_x_reg[15] && (origin_x_reg >= {4'b0000, screen_width_reg}))
                     || (!origin_y_reg[15] && (origin_y_reg >= {4'b0000, screen_height_reg}));
    assign fs = s_tuser && !origin_bad;

    assign cur_phase = fs ? bmp565_pkg::PH_HEADER : phase_reg;
    assign cur_hc    = fs ? 6'd0 : header_count_reg;
    assign cur_hw    = fs ? 32'd0 : header_word_reg;
    assign cur_fmt   = fs ? 1'b1 : format_ok_reg;
    assign cur_pos   = fs ? 32'd0 : stream_pos_reg;
    assign cur_row   = fs ? 16'd0 : row_index_reg;
    assign cur_col   = fs ? 16'd0 : col_index_reg;
    assign cur_bip   = fs ? 2'd0 : byte_in_pixel_reg;
    assign cur_pad   = fs ? 2'd0 : pad_left_reg;

    assign px = {{2{origin_x_reg[15]}}, origin_x_reg} + {2'b00, cur_col};
    assign py = {{2{origin_y_reg[15]}}, origin_y_reg} + {2'b00, image_height_reg}
              - 18'd1 - {2'b00, cur_row};
    assign end_row = ({1'b0, cur_col} + 17'd1) >= {1'b0, image_width_reg};
    assign fin     = end_row && (({1'b0, cur_row} + 17'd1) >= {1'b0, image_height_reg});

    always_comb
    begin
        pix_res.kind    = bmp565_pkg::KIND_PIXEL;
        pix_res.pixel_x = px;
        pix_res.pixel_y = py;
        pix_res.color   = {s_tdata & bmp565_pkg::RED_MASK, 8'h00}
                        | {5'b00000, green_hold_reg & bmp565_pkg::GREEN_MASK, 3'b000}
                        | {11'd0, blue_hold_reg[7:3]};
        pix_res.in_view = !px[17] && (px < {6'd0, screen_width_reg})
                       && !py[17] && (py < {6'd0, screen_height_reg});
        pix_res.last    = fin;
    end

    always_comb
    begin
        phase_next         = cur_phase;
        header_count_next  = cur_hc;
        stream_pos_next    = (cur_pos != 32'hFFFF_FFFF) ? cur_pos + 32'd1 : cur_pos;
        data_offset_next   = fs ? 32'd0 : data_offset_reg;
        image_width_next   = fs ? 16'd0 : image_width_reg;
        image_height_next  = fs ? 16'd0 : image_height_reg;
        header_word_next   = cur_hw;
        format_ok_next     = cur_fmt;
        row_index_next     = cur_row;
        col_index_next     = cur_col;
        byte_in_pixel_next = cur_bip;
        pad_left_next      = cur_pad;
        blue_hold_next     = fs ? 8'd0 : blue_hold_reg;
        green_hold_next    = fs ? 8'd0 : green_hold_reg;
        res_valid          = 1'b0;
        res                = '0;
        res.last           = 1'b1;
        do_pixel           = 1'b0;
        fmt_final          = cur_fmt;

        if (s_tuser && origin_bad)
        begin
            phase_next      = bmp565_pkg::PH_DONE;
            stream_pos_next = 32'd1;
            res_valid       = 1'b1;
            res.kind        = bmp565_pkg::KIND_OFFSCREEN;
        end
        else
        begin
            case (cur_phase)
                bmp565_pkg::PH_HEADER:
                begin
                    header_word_next  = {s_tdata, cur_hw[31:8]};
                    header_count_next = cur_hc + 6'd1;
                    case (cur_hc)
                        bmp565_pkg::HDR_SIGNATURE:
                        begin
                            if (header_word_next[31:16] != bmp565_pkg::BMP_SIGNATURE)
                            begin
                                phase_next = bmp565_pkg::PH_DONE;
                                res_valid  = 1'b1;
                                res.kind   = bmp565_pkg::KIND_BAD_SIG;
                            end
                        end
                        bmp565_pkg::HDR_OFFSET:
                            data_offset_next = header_word_next;
                        bmp565_pkg::HDR_WIDTH:
                            image_width_next = header_word_next[15:0];
                        bmp565_pkg::HDR_HEIGHT:
                            image_height_next = header_word_next[15:0];
                        bmp565_pkg::HDR_PLANES:
                        begin
                            if (header_word_next[31:16] != bmp565_pkg::BMP_PLANES)
                                format_ok_next = 1'b0;
                        end
                        bmp565_pkg::HDR_BPP:
                        begin
                            if (header_word_next[31:16] != bmp565_pkg::BMP_BPP)
                                format_ok_next = 1'b0;
                        end
                        bmp565_pkg::HDR_LAST:
                        begin
                            fmt_final      = cur_fmt && (header_word_next == 32'd0);
                            format_ok_next = fmt_final;
                            if (!fmt_final)
                            begin
                                phase_next = bmp565_pkg::PH_DONE;
                                res_valid  = 1'b1;
                                res.kind   = bmp565_pkg::KIND_BAD_FMT;
                            end
                            else if (data_offset_reg < bmp565_pkg::HEADER_LEN)
                            begin
                                phase_next = bmp565_pkg::PH_DONE;
                                res_valid  = 1'b1;
                                res.kind   = bmp565_pkg::KIND_BAD_OFS;
                            end
                            else if (image_width_reg == 16'd0 || image_height_reg == 16'd0)
                            begin
                                phase_next = bmp565_pkg::PH_DONE;
                            end
                            else
                            begin
                                row_index_next     = 16'd0;
                                col_index_next     = 16'd0;
                                byte_in_pixel_next = 2'd0;
                                pad_left_next      = 2'd0;
                                phase_next = (data_offset_reg == bmp565_pkg::HEADER_LEN)
                                           ? bmp565_pkg::PH_PIXELS : bmp565_pkg::PH_SKIP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                bmp565_pkg::PH_SKIP:
                begin
                    if (cur_pos == data_offset_reg)
                    begin
                        phase_next = bmp565_pkg::PH_PIXELS;
                        do_pixel   = 1'b1;
                    end
                end
                bmp565_pkg::PH_PIXELS:
                    do_pixel = 1'b1;
                default:
                begin
                end
            endcase

            if (do_pixel)
            begin
                if (cur_pad != 2'd0)
                begin
                    pad_left_next = cur_pad - 2'd1;
                end
                else if (cur_bip == 2'd0)
                begin
                    blue_hold_next     = s_tdata;
                    byte_in_pixel_next = 2'd1;
                end
                else if (cur_bip == 2'd1)
                begin
                    green_hold_next    = s_tdata;
                    byte_in_pixel_next = 2'd2;
                end
                else
                begin
                    byte_in_pixel_next = 2'd0;
                    res_valid          = 1'b1;
                    res                = pix_res;
                    if (fin)
                    begin
                        phase_next = bmp565_pkg::PH_DONE;
                    end
                    else if (end_row)
                    begin
                        col_index_next = 16'd0;
                        row_index_next = cur_row + 16'd1;
                        pad_left_next  = image_width_reg[1:0];
                    end
                    else
                    begin
                        col_index_next = cur_col + 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg      <= 16'd0;
            origin_y_reg      <= 16'd0;
            screen_width_reg  <= bmp565_pkg::SCREEN_WIDTH_RESET;
            screen_height_reg <= bmp565_pkg::SCREEN_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bmp565_pkg::CFG_ORIGIN_X:      origin_x_reg      <= cfg_data;
                bmp565_pkg::CFG_ORIGIN_Y:      origin_y_reg      <= cfg_data;
                bmp565_pkg::CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[11:0];
                bmp565_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= bmp565_pkg::PH_IDLE;
            header_count_reg  <= 6'd0;
            stream_pos_reg    <= 32'd0;
            data_offset_reg   <= 32'd0;
            image_width_reg   <= 16'd0;
            image_height_reg  <= 16'd0;
            header_word_reg   <= 32'd0;
            format_ok_reg     <= 1'b1;
            row_index_reg     <= 16'd0;
            col_index_reg     <= 16'd0;
            byte_in_pixel_reg <= 2'd0;
            pad_left_reg      <= 2'd0;
            blue_hold_reg     <= 8'd0;
            green_hold_reg    <= 8'd0;
        end
        else if (in_acc)
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            stream_pos_reg    <= stream_pos_next;
            data_offset_reg   <= data_offset_next;
            image_width_reg   <= image_width_next;
            image_height_reg  <= image_height_next;
            header_word_reg   <= header_word_next;
            format_ok_reg     <= format_ok_next;
            row_index_reg     <= row_index_next;
            col_index_reg     <= col_index_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            pad_left_reg      <= pad_left_next;
            blue_hold_reg     <= blue_hold_next;
            green_hold_reg    <= green_hold_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_acc && res_valid;
            end
        end
        else if (in_acc && res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (in_acc && res_valid)
                out_reg <= res;
        end
        else if (in_acc && res_valid)
        begin
            skid_reg <= res;
        end
    end

endmodule

// ===== test/bmp24_stream_to_rgb565_unit_tb.sv =====
// Testbench for the BMP to RGB565 stream decoder: directed and random files checked item by item.
`timescale 1ns / 1ps

module bmp24_stream_to_rgb565_unit_tb;

    class bmp_decode_checker;
        bmp565_pkg::res_t  decode_results_due[$];
        int                fails;
        int                results_seen;
        logic signed [15:0] org_x;
        logic signed [15:0] org_y;
        logic [11:0]       scr_w;
        logic [11:0]       scr_h;
        logic [2:0]        phase;
        logic [5:0]        hdr_count;
        logic [31:0]       pos_count;
        logic [31:0]       data_ofs;
        logic [31:0]       hdr_word;
        logic [15:0]       img_w;
        logic [15:0]       img_h;
        logic [15:0]       row;
        logic [15:0]       col;
        logic              fmt_ok;
        logic [1:0]        byte_sel;
        logic [1:0]        pad_left;
        logic [7:0]        blue_q;
        logic [7:0]        green_q;

        function new();
            org_x = '0;
            org_y = '0;
            scr_w = bmp565_pkg::SCREEN_WIDTH_RESET;
            scr_h = bmp565_pkg::SCREEN_HEIGHT_RESET;
            phase = bmp565_pkg::PH_IDLE;
            hdr_count = '0;
            pos_count = '0;
            data_ofs = '0;
            hdr_word = '0;
            img_w = '0;
            img_h = '0;
            row = '0;
            col = '0;
            fmt_ok = 1'b1;
            byte_sel = '0;
            pad_left = '0;
            blue_q = '0;
            green_q = '0;
            fails = 0;
            results_seen = 0;
        endfunction

        task report(string msg);
            if (fails < 40)
                $display("%0t mismatch: %s", $time, msg);
            fails++;
        endtask

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                bmp565_pkg::CFG_ORIGIN_X:      org_x = val;
                bmp565_pkg::CFG_ORIGIN_Y:      org_y = val;
                bmp565_pkg::CFG_SCREEN_WIDTH:  scr_w = val[11:0];
                bmp565_pkg::CFG_SCREEN_HEIGHT: scr_h = val[11:0];
                default: ;
            endcase
        endfunction

        function void push_error(logic [2:0] kind);
            bmp565_pkg::res_t r;
            r = '0;
            r.kind = kind;
            r.last = 1'b1;
            decode_results_due.push_back(r);
            phase = bmp565_pkg::PH_DONE;
        endfunction

        function void pixel_byte(logic [7:0] b);
            bmp565_pkg::res_t r;
            int   px;
            int   py;
            logic end_row;
            if (pad_left != 0)
            begin
                pad_left--;
                return;
            end
            if (byte_sel == 2'd0)
            begin
                blue_q = b;
                byte_sel = 2'd1;
                return;
            end
            if (byte_sel == 2'd1)
            begin
                green_q = b;
                byte_sel = 2'd2;
                return;
            end
            byte_sel = 2'd0;
            px = int'(org_x) + int'(col);
            py = int'(org_y) + int'(img_h) - 1 - int'(row);
            r.kind = bmp565_pkg::KIND_PIXEL;
            r.pixel_x = px[17:0];
            r.pixel_y = py[17:0];
            r.color = {b[7:3], green_q[7:2], blue_q[7:3]};
            r.in_view = (px >= 0) && (px < int'(scr_w)) && (py >= 0) && (py < int'(scr_h));
            end_row = (int'(col) + 1 >= int'(img_w));
            r.last = end_row && (int'(row) + 1 >= int'(img_h));
            decode_results_due.push_back(r);
            if (r.last)
                phase = bmp565_pkg::PH_DONE;
            else if (end_row)
            begin
                col = '0;
                row++;
                pad_left = img_w[1:0];
            end
            else
                col++;
        endfunction

        function void take_byte(logic [7:0] b, logic start);
            logic [31:0] at;
            logic [5:0]  idx;
            if (start)
            begin
                if (int'(org_x) >= int'(scr_w) || int'(org_y) >= int'(scr_h))
                begin
                    pos_count = 32'd1;
                    push_error(bmp565_pkg::KIND_OFFSCREEN);
                    return;
                end
                phase = bmp565_pkg::PH_HEADER;
                hdr_count = '0;
                pos_count = '0;
                hdr_word = '0;
                fmt_ok = 1'b1;
                data_ofs = '0;
                img_w = '0;
                img_h = '0;
                row = '0;
                col = '0;
                byte_sel = '0;
                pad_left = '0;
                blue_q = '0;
                green_q = '0;
            end
            at = pos_count;
            if (pos_count != '1)
                pos_count++;
            case (phase)
                bmp565_pkg::PH_HEADER:
                begin
                    idx = hdr_count;
                    hdr_word = {b, hdr_word[31:8]};
                    hdr_count++;
                    case (idx)
                        bmp565_pkg::HDR_SIGNATURE:
                            if (hdr_word[31:16] != bmp565_pkg::BMP_SIGNATURE)
                                push_error(bmp565_pkg::KIND_BAD_SIG);
                        bmp565_pkg::HDR_OFFSET: data_ofs = hdr_word;
                        bmp565_pkg::HDR_WIDTH:  img_w = hdr_word[15:0];
                        bmp565_pkg::HDR_HEIGHT: img_h = hdr_word[15:0];
                        bmp565_pkg::HDR_PLANES:
                            if (hdr_word[31:16] != bmp565_pkg::BMP_PLANES)
                                fmt_ok = 1'b0;
                        bmp565_pkg::HDR_BPP:
                            if (hdr_word[31:16] != bmp565_pkg::BMP_BPP)
                                fmt_ok = 1'b0;
                        bmp565_pkg::HDR_LAST:
                        begin
                            if (hdr_word != '0)
                                fmt_ok = 1'b0;
                            if (!fmt_ok)
                                push_error(bmp565_pkg::KIND_BAD_FMT);
                            else if (data_ofs < bmp565_pkg::HEADER_LEN)
                                push_error(bmp565_pkg::KIND_BAD_OFS);
                            else if (img_w == '0 || img_h == '0)
                                phase = bmp565_pkg::PH_DONE;
                            else
                            begin
                                row = '0;
                                col = '0;
                                byte_sel = '0;
                                pad_left = '0;
                                phase = (data_ofs == bmp565_pkg::HEADER_LEN)
                                      ? bmp565_pkg::PH_PIXELS : bmp565_pkg::PH_SKIP;
                            end
                        end
                        default: ;
                    endcase
                end
                bmp565_pkg::PH_SKIP:
                    if (at == data_ofs)
                    begin
                        phase = bmp565_pkg::PH_PIXELS;
                        pixel_byte(b);
                    end
                bmp565_pkg::PH_PIXELS: pixel_byte(b);
                default: ;
            endcase
        endfunction

        task check_output(logic [2:0] kind, logic [55:0] data, logic last_flag);
            bmp565_pkg::res_t want;
            bmp565_pkg::res_t got;
            string diff;
            got.kind = kind;
            got.pixel_x = data[17:0];
            got.pixel_y = data[35:18];
            got.color = data[51:36];
            got.in_view = data[52];
            got.last = last_flag;
            results_seen++;
            if (decode_results_due.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing pending (kind %0d)",
                                 results_seen, kind));
                return;
            end
            want = decode_results_due.pop_front();
            diff = "";
            if (got.kind !== want.kind)       diff = {diff, " kind"};
            if (got.pixel_x !== want.pixel_x) diff = {diff, " pixel_x"};
            if (got.pixel_y !== want.pixel_y) diff = {diff, " pixel_y"};
            if (got.color !== want.color)     diff = {diff, " color"};
            if (got.in_view !== want.in_view) diff = {diff, " in_view"};
            if (got.last !== want.last)       diff = {diff, " last"};
            if (diff != "")
                report($sformatf({"result %0d:%s wrong; got %0d/%h/%h/%h/%b/%b",
                                  " want %0d/%h/%h/%h/%b/%b"}, results_seen, diff,
                                 got.kind, got.pixel_x, got.pixel_y, got.color,
                                 got.in_view, got.last, want.kind, want.pixel_x,
                                 want.pixel_y, want.color, want.in_view, want.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    bmp_decode_checker decode_chk;
    logic              tx_idle;
    logic              rx_idle;
    int                rx_hold;
    int                file_bytes;

    bmp24_stream_to_rgb565_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_span();
        case ($urandom_range(0, 9))
            0:       return 4095;
            1:       return 1;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    function automatic int pick_origin(int span);
        case ($urandom_range(0, 11))
            0:       return -32768;
            1:       return int'($urandom_range(0, 65535)) - 32768;
            2:       return span;
            default: return int'($urandom_range(0, span + 8)) - 8;
        endcase
    endfunction

    // stall the result side
    always @(negedge clk)
    begin
        if (rx_hold == 0 && rx_idle)
            rx_hold = pick_gap();
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold--;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            decode_chk.check_output(m_tuser, m_tdata, m_tlast);
    end

    task send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= start;
        do @(posedge clk); while (!s_tready);
        decode_chk.take_byte(b, start);
        @(negedge clk);
    endtask

    task automatic send_bmp(input int w, input int h, input int ofs, input logic [15:0] sig,
                            input logic [15:0] planes, input logic [15:0] bpp,
                            input logic [31:0] comp, input int keep, input int extra);
        logic [7:0] octets[$];
        int         n;
        for (int i = 0; i < 34; i++)
            octets.push_back(8'($urandom_range(0, 255)));
        for (int k = 0; k < 2; k++)
        begin
            octets[k] = sig[8*k +: 8];
            octets[18 + k] = w[8*k +: 8];
            octets[22 + k] = h[8*k +: 8];
            octets[26 + k] = planes[8*k +: 8];
            octets[28 + k] = bpp[8*k +: 8];
        end
        for (int k = 0; k < 4; k++)
        begin
            octets[10 + k] = ofs[8*k +: 8];
            octets[30 + k] = comp[8*k +: 8];
        end
        for (int i = 34; i < ofs; i++)
            octets.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < h * (w * 3 + w % 4); i++)
            octets.push_back(8'($urandom_range(0, 255)));
        n = (keep >= 0 && keep < octets.size()) ? keep : octets.size();
        for (int i = 0; i < n; i++)
            send_byte(octets[i], i == 0);
        repeat (extra) send_byte(8'($urandom_range(0, 255)), 1'b0);
        file_bytes += n;
    endtask

    task wait_drained();
        s_tvalid <= 1'b0;
        while (decode_chk.decode_results_due.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task cfg_write(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        decode_chk.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task apply_setup(input int ox, input int oy, input int sw, input int sh);
        wait_drained();
        cfg_write(bmp565_pkg::CFG_ORIGIN_X, ox[15:0]);
        cfg_write(bmp565_pkg::CFG_ORIGIN_Y, oy[15:0]);
        cfg_write(bmp565_pkg::CFG_SCREEN_WIDTH, sw[15:0]);
        cfg_write(bmp565_pkg::CFG_SCREEN_HEIGHT, sh[15:0]);
    endtask

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int sw;
        int sh;
        int w;
        int h;
        int ofs;
        int guard;
        decode_chk = new();
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        rx_hold = 0;
        file_bytes = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drop bytes before any file start
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        apply_setup(0, 0, 536, 240);
        send_bmp(2, 2, 34, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                 bmp565_pkg::BMP_BPP, 0, -1, 0);
        send_bmp(1, 1, 34, bmp565_pkg::BMP_SIGNATURE ^ 16'h0001, bmp565_pkg::BMP_PLANES,
                 bmp565_pkg::BMP_BPP, 0, -1, 0);
        send_bmp(1, 1, 34, bmp565_pkg::BMP_SIGNATURE, 16'd2,
                 bmp565_pkg::BMP_BPP, 0, -1, 0);
        send_bmp(1, 1, 34, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                 16'd32, 0, -1, 0);
        send_bmp(1, 1, 34, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                 bmp565_pkg::BMP_BPP, 1, -1, 0);
        send_bmp(1, 1, 20, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                 bmp565_pkg::BMP_BPP, 0, -1, 0);
        send_bmp(1, 1, 0, bmp565_pkg::BMP_SIGNATURE, 16'd0,
                 bmp565_pkg::BMP_BPP, 0, -1, 0);
        send_bmp(0, 2, 34, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                 bmp565_pkg::BMP_BPP, 0, -1, 3);
        send_bmp(2, 0, 34, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                 bmp565_pkg::BMP_BPP, 0, -1, 3);
        send_bmp(5, 3, 40, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                 bmp565_pkg::BMP_BPP, 0, -1, 4);
        send_bmp(3, 2, 34, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                 bmp565_pkg::BMP_BPP, 0, -1, 0);
        // restart in the middle of the pixel data
        send_bmp(4, 2, 34, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                 bmp565_pkg::BMP_BPP, 0, 50, 0);
        send_bmp(1, 1, 34, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                 bmp565_pkg::BMP_BPP, 0, -1, 0);
        apply_setup(-32768, -32768, 4095, 4095);
        send_bmp(2, 2, 34, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                 bmp565_pkg::BMP_BPP, 0, -1, 0);
        apply_setup(32767, 0, 4095, 4095);
        send_bmp(1, 1, 34, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                 bmp565_pkg::BMP_BPP, 0, -1, 0);
        apply_setup(0, 32767, 1, 1);
        send_bmp(1, 1, 34, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                 bmp565_pkg::BMP_BPP, 0, -1, 0);
        apply_setup(0, 0, 1, 1);
        send_bmp(2, 2, 34, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                 bmp565_pkg::BMP_BPP, 0, -1, 0);
        apply_setup(-1, -1, 3, 2);
        send_bmp(3, 3, 36, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                 bmp565_pkg::BMP_BPP, 0, -1, 0);

        while (file_bytes < 1500)
        begin
            sw = pick_span();
            sh = pick_span();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            apply_setup(pick_origin(sw), pick_origin(sh), sw, sh);
            repeat ($urandom_range(1, 4))
            begin
                w = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 48) : $urandom_range(1, 9);
                h = (w > 9) ? $urandom_range(1, 2) : $urandom_range(1, 5);
                ofs = ($urandom_range(0, 2) == 0) ? 34 + $urandom_range(1, 12) : 34;
                case ($urandom_range(0, 19))
                    0: send_bmp(w, h, ofs,
                                bmp565_pkg::BMP_SIGNATURE ^ (16'd1 << $urandom_range(0, 15)),
                                bmp565_pkg::BMP_PLANES, bmp565_pkg::BMP_BPP, 0, -1, 0);
                    1: send_bmp(w, h, ofs, bmp565_pkg::BMP_SIGNATURE,
                                bmp565_pkg::BMP_PLANES ^ (16'd1 << $urandom_range(0, 15)),
                                bmp565_pkg::BMP_BPP, 0, -1, 0);
                    2: send_bmp(w, h, ofs, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                                bmp565_pkg::BMP_BPP ^ (16'd1 << $urandom_range(0, 15)),
                                0, -1, 0);
                    3: send_bmp(w, h, ofs, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                                bmp565_pkg::BMP_BPP, 32'd1 << $urandom_range(0, 31), -1, 0);
                    4: send_bmp(w, h, $urandom_range(0, 33), bmp565_pkg::BMP_SIGNATURE,
                                bmp565_pkg::BMP_PLANES, bmp565_pkg::BMP_BPP, 0, -1, 0);
                    5: send_bmp(($urandom_range(0, 1) == 0) ? 0 : w, (w > 9) ? 0 : h, ofs,
                                bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                                bmp565_pkg::BMP_BPP, 0, -1, 2);
                    6: send_bmp(w, h, ofs, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                                bmp565_pkg::BMP_BPP, 0,
                                $urandom_range(1, ofs + w * h * 3), 0);
                    7: repeat ($urandom_range(1, 6))
                           send_byte(8'($urandom_range(0, 255)), 1'b0);
                    8: send_bmp(w, h, ofs, bmp565_pkg::BMP_SIGNATURE, bmp565_pkg::BMP_PLANES,
                                bmp565_pkg::BMP_BPP, 0, -1, $urandom_range(1, 8));
                    default: send_bmp(w, h, ofs, bmp565_pkg::BMP_SIGNATURE,
                                      bmp565_pkg::BMP_PLANES, bmp565_pkg::BMP_BPP, 0, -1, 0);
                endcase
            end
        end

        s_tvalid <= 1'b0;
        guard = 0;
        while (decode_chk.decode_results_due.size() != 0 && guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (10) @(negedge clk);
        if (decode_chk.decode_results_due.size() != 0)
            decode_chk.report($sformatf("%0d results never arrived",
                                        decode_chk.decode_results_due.size()));
        if (decode_chk.fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
